/* rtl/csc_pkg.sv */
// Package for the client session sequence checker.
// Holds the transfer payload types, status codes and controller state encoding.
// Depends on nothing.
package csc_pkg;

   // Status codes of a result transfer
   localparam logic [2:0] STATUS_ACCEPTED   = 3'd0;
   localparam logic [2:0] STATUS_WRONG_CONN = 3'd1;
   localparam logic [2:0] STATUS_BAD_SEQ    = 3'd2;
   localparam logic [2:0] STATUS_STAMPED    = 3'd3;
   localparam logic [2:0] STATUS_NO_CONN    = 3'd4;

   // Item kinds
   localparam logic KIND_REQUEST  = 1'b0;
   localparam logic KIND_RESPONSE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  client_id;
      logic [7:0]  conn_id;
      logic [31:0] seq_num;
      logic [63:0] rx_time;
   } csc_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_client;
      logic [7:0]  send_conn;
      logic [31:0] out_seq;
      logic [63:0] fwd_time;
   } csc_rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } csc_state_type;

endpackage

/* rtl/csc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. Depends on nothing.
module csc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/client_session_sequence_checker.sv */
// Client session sequence checker: per-client session table in one RAM.
// Path: the table is read at the request transfer, the entry is checked in ST_LOOKUP, then registered.
// A new request is taken only in ST_IDLE, so the table RAM is read and written back per item.
// Reset: synchronous; a clearing pass then writes every entry
// (unbound, expected and outgoing numbers 1) while req_stall is held high.
// Depends on csc_pkg and csc_ram.
module client_session_sequence_checker #(
   parameter int MAX_CLIENTS = 256,
   parameter int SEQ_WIDTH   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  csc_pkg::csc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output csc_pkg::csc_rsp_type rsp_data
);

   localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int ENT_W = 1 + 8 + 2 * SEQ_WIDTH;
   localparam int CMP_W = 13;

   // Entry layout
   localparam int FLAG_BIT = ENT_W - 1;
   localparam int CONN_HI  = ENT_W - 2;
   localparam int EXP_HI   = 2 * SEQ_WIDTH - 1;
   localparam int OUT_HI   = SEQ_WIDTH - 1;

   csc_pkg::csc_state_type state_ff, state_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;
   csc_pkg::csc_req_type   item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   csc_pkg::csc_rsp_type   rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   load_rsp;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [ENT_W-1:0]       wr_data;
   logic [ENT_W-1:0]       rd_data;
   logic [IDX_W-1:0]       rd_addr;

   // Entry fields of the item under lookup
   logic                   ent_flag;
   logic [7:0]             ent_conn;
   logic [SEQ_WIDTH-1:0]   ent_exp;
   logic [SEQ_WIDTH-1:0]   ent_out;
   logic                   item_in_table;
   logic [IDX_W-1:0]       item_idx;
   logic [SEQ_WIDTH-1:0]   item_seq;
   logic [7:0]             conn_eff;
   logic                   upd_en;
   logic [ENT_W-1:0]       upd_data;
   csc_pkg::csc_rsp_type   result;

   assign req_accept = req_valid && !req_stall;
   assign rd_addr    = (IDX_W)'({{CMP_W{1'b0}}, req_data.client_id});

   csc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_CLIENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Unpack the entry and the held item
   assign ent_flag      = rd_data[FLAG_BIT];
   assign ent_conn      = rd_data[CONN_HI -: 8];
   assign ent_exp       = rd_data[EXP_HI -: SEQ_WIDTH];
   assign ent_out       = rd_data[OUT_HI -: SEQ_WIDTH];
   assign item_in_table = {(CMP_W - 8)'(0), item_ff.client_id} < CMP_W'(MAX_CLIENTS);
   assign item_idx      = (IDX_W)'({{CMP_W{1'b0}}, item_ff.client_id});
   assign item_seq      = SEQ_WIDTH'(item_ff.seq_num);
   // An unbound client binds to the arriving connection, so it always matches
   assign conn_eff      = ent_flag ? ent_conn : item_ff.conn_id;

   // Check the item against its entry and build the write-back
   always_comb begin
      result            = '0;
      result.out_client = item_ff.client_id;
      upd_en            = 1'b0;
      upd_data          = rd_data;
      if (item_ff.req_type == csc_pkg::KIND_REQUEST) begin
         if (!item_in_table) begin
            result.status = csc_pkg::STATUS_WRONG_CONN;
         end else begin
            upd_data[FLAG_BIT]        = 1'b1;
            upd_data[CONN_HI -: 8]    = conn_eff;
            upd_en                    = !ent_flag;
            if (conn_eff != item_ff.conn_id) begin
               result.status = csc_pkg::STATUS_WRONG_CONN;
            end else if (item_seq != ent_exp) begin
               result.status = csc_pkg::STATUS_BAD_SEQ;
            end else begin
               result.status              = csc_pkg::STATUS_ACCEPTED;
               result.fwd_time            = item_ff.rx_time;
               upd_data[EXP_HI -: SEQ_WIDTH] = ent_exp + SEQ_WIDTH'(1);
               upd_en                     = 1'b1;
            end
         end
      end else begin
         if (!item_in_table || !ent_flag) begin
            result.status = csc_pkg::STATUS_NO_CONN;
         end else begin
            result.status                 = csc_pkg::STATUS_STAMPED;
            result.send_conn              = ent_conn;
            result.out_seq                = 32'(ent_out);
            upd_data[OUT_HI -: SEQ_WIDTH] = ent_out + SEQ_WIDTH'(1);
            upd_en                        = 1'b1;
         end
      end
   end

   // Sequence the clearing pass, accept and lookup
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_stall    = 1'b1;
      load_rsp     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = item_idx;
      wr_data      = upd_data;
      case (state_ff)
         csc_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {1'b0, 8'd0, SEQ_WIDTH'(1), SEQ_WIDTH'(1)};
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MAX_CLIENTS - 1)) begin
               state_in = csc_pkg::ST_IDLE;
            end
         end
         csc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = csc_pkg::ST_LOOKUP;
            end
         end
         csc_pkg::ST_LOOKUP: begin
            // Wait here while the output register still holds an untaken transfer
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               wr_en    = upd_en;
               state_in = csc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csc_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         item_ff <= req_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* verif/csc_session_monitor.sv */
// Transfer monitor for the client session sequence checker.
// Watches both channels, predicts each result from its own session table, compares.
// Depends on csc_pkg.
module csc_session_monitor
   import csc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  csc_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  csc_rsp_type rsp_data,
   output int          failures,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Session table of the prediction: binding, then next inbound and outbound numbers
   bit          link_valid    [256];
   logic [7:0]  link_conn     [256];
   logic [31:0] next_inbound  [256];
   logic [31:0] next_outbound [256];

   csc_rsp_type pending_outcomes [$];
   int          mismatch_count;

   initial begin
      failures = 0;
      pending  = 0;
      mismatch_count = 0;
   end

   // Work out the result of one item and update the session table
   function automatic csc_rsp_type session_outcome(input csc_req_type item);
      csc_rsp_type res;
      logic [7:0]  c;
      res = '0;
      c = item.client_id;
      res.out_client = c;
      if (item.req_type == KIND_REQUEST) begin
         // first request seen binds the client, whatever else is wrong with it
         if (!link_valid[c]) begin
            link_valid[c] = 1'b1;
            link_conn[c]  = item.conn_id;
         end
         if (link_conn[c] != item.conn_id) begin
            res.status = STATUS_WRONG_CONN;
         end else if (item.seq_num != next_inbound[c]) begin
            res.status = STATUS_BAD_SEQ;
         end else begin
            next_inbound[c] = next_inbound[c] + 32'd1;
            res.fwd_time = item.rx_time;
            res.status   = STATUS_ACCEPTED;
         end
      end else if (!link_valid[c]) begin
         res.status = STATUS_NO_CONN;
      end else begin
         res.status    = STATUS_STAMPED;
         res.send_conn = link_conn[c];
         res.out_seq   = next_outbound[c];
         next_outbound[c] = next_outbound[c] + 32'd1;
      end
      return res;
   endfunction

   task automatic report_field(input string name, input longint unsigned want,
                               input longint unsigned got);
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      csc_rsp_type want;
      if (reset) begin
         // clear the table as the block does after reset
         for (int k = 0; k < 256; k++) begin
            link_valid[k]    = 1'b0;
            link_conn[k]     = 8'd0;
            next_inbound[k]  = 32'd1;
            next_outbound[k] = 32'd1;
         end
         pending_outcomes.delete();
      end else begin
         // compare the result transfer before queueing a new expectation
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t ns: result transfer with nothing expected, status %0d client %0d",
                        $time, rsp_data.status, rsp_data.out_client);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_data.status !== want.status)
                  report_field("status", want.status, rsp_data.status);
               if (rsp_data.out_client !== want.out_client)
                  report_field("out_client", want.out_client, rsp_data.out_client);
               if (rsp_data.send_conn !== want.send_conn)
                  report_field("send_conn", want.send_conn, rsp_data.send_conn);
               if (rsp_data.out_seq !== want.out_seq)
                  report_field("out_seq", want.out_seq, rsp_data.out_seq);
               if (rsp_data.fwd_time !== want.fwd_time)
                  report_field("fwd_time", want.fwd_time, rsp_data.fwd_time);
            end
         end
         if (req_valid && !req_stall)
            pending_outcomes.push_back(session_outcome(req_data));
      end
      failures <= mismatch_count;
      pending  <= pending_outcomes.size();
   end

endmodule

/* verif/client_session_sequence_checker_tb.sv */
// Testbench top for the client session sequence checker.
// Drives directed and random request/response transfers with idle bursts; needs
// csc_pkg, the block and csc_session_monitor.
module client_session_sequence_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csc_pkg::*;

   localparam int RANDOM_ITEMS = 730;
   localparam int QUIET_TAIL   = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   csc_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   csc_rsp_type rsp_data;
   int          failures;
   int          pending;

   // Stimulus bookkeeping: which clients are bound, and the number each wants next
   bit          gen_bound [256];
   logic [7:0]  gen_conn  [256];
   logic [31:0] gen_next  [256];
   int          n_requests;
   int          n_responses;
   bit          quiet;

   client_session_sequence_checker u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   csc_session_monitor u_monitor (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic csc_req_type make_item(input logic kind, input logic [7:0] client,
                                             input logic [7:0] conn, input logic [31:0] seq,
                                             input logic [63:0] when);
      csc_req_type item;
      item.req_type  = kind;
      item.client_id = client;
      item.conn_id   = conn;
      item.seq_num   = seq;
      item.rx_time   = when;
      return item;
   endfunction

   // Offer one item after an optional idle burst; hold it until the transfer
   task automatic send_item(input csc_req_type item);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      // track binding and the next good number so that later items can be well formed
      if (item.req_type == KIND_REQUEST) begin
         n_requests++;
         if (!gen_bound[item.client_id]) begin
            gen_bound[item.client_id] = 1'b1;
            gen_conn[item.client_id]  = item.conn_id;
         end
         if (gen_conn[item.client_id] == item.conn_id && gen_next[item.client_id] == item.seq_num)
            gen_next[item.client_id] = item.seq_num + 32'd1;
      end else begin
         n_responses++;
      end
   endtask

   // Random item: mostly in-order sessions on a few clients, the rest broken or noise
   function automatic csc_req_type random_item();
      logic [7:0]  c;
      logic [7:0]  conn;
      logic [31:0] seq;
      logic [63:0] when;
      int          pick;
      c    = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      when = {$urandom, $urandom};
      conn = gen_bound[c] ? gen_conn[c] : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return make_item(KIND_REQUEST, c, conn, gen_next[c], when);
      if (pick < 75)
         return make_item(KIND_RESPONSE, c, 8'($urandom), $urandom, when);
      if (pick < 85) begin
         // wrong connection once bound
         if (gen_bound[c]) conn = conn ^ 8'($urandom_range(1, 255));
         return make_item(KIND_REQUEST, c, conn, gen_next[c], when);
      end
      if (pick < 95) begin
         // replay of the last number, or any other wrong number
         seq = ($urandom_range(0, 1) == 0) ? gen_next[c] - 32'd1 : $urandom;
         if (seq == gen_next[c]) seq = seq + 32'd1;
         return make_item(KIND_REQUEST, c, conn, seq, when);
      end
      return make_item(1'($urandom), c, 8'($urandom), $urandom, when);
   endfunction

   // Result side: random stall bursts, with long runs free of stall; none at the tail
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(30, 80)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         if (!quiet) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding", pending);
      $display("client_session_sequence_checker_tb: FAIL");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      quiet       = 1'b0;
      n_requests  = 0;
      n_responses = 0;
      for (int k = 0; k < 256; k++) begin
         gen_bound[k] = 1'b0;
         gen_conn[k]  = 8'd0;
         gen_next[k]  = 32'd1;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: unbound responses, binding, drops of each kind, stamping, field extremes
      send_item(make_item(KIND_RESPONSE, 8'd0, 8'd0, 32'd0, 64'd0));
      send_item(make_item(KIND_REQUEST, 8'd0, 8'd0, 32'd1, 64'd0));
      send_item(make_item(KIND_REQUEST, 8'd0, 8'd0, 32'd1, 64'd7));
      send_item(make_item(KIND_REQUEST, 8'd0, 8'd1, 32'd2, 64'd9));
      send_item(make_item(KIND_REQUEST, 8'd0, 8'd0, 32'd2, '1));
      send_item(make_item(KIND_RESPONSE, 8'd0, '1, '1, '1));
      send_item(make_item(KIND_RESPONSE, 8'd0, 8'd0, 32'd0, 64'd0));
      // binding happens even when the number is wrong
      send_item(make_item(KIND_REQUEST, 8'd255, 8'd255, 32'd0, 64'd1));
      send_item(make_item(KIND_REQUEST, 8'd255, 8'd255, '1, '1));
      send_item(make_item(KIND_REQUEST, 8'd255, 8'd255, 32'd1, 64'hAAAA_AAAA_AAAA_AAAA));
      send_item(make_item(KIND_RESPONSE, 8'd255, 8'd0, 32'd0, 64'd0));
      send_item(make_item(KIND_REQUEST, 8'd128, 8'd0, 32'd1, 64'h5555_5555_5555_5555));
      send_item(make_item(KIND_REQUEST, 8'd128, 8'hFF, 32'd2, 64'd3));
      send_item(make_item(KIND_RESPONSE, 8'd1, 8'h55, 32'd1, 64'd0));
      send_item(make_item(KIND_REQUEST, 8'd1, 8'h55, 32'h8000_0000, 64'd4));
      send_item(make_item(KIND_REQUEST, 8'd1, 8'h55, 32'd1, 64'h8000_0000_0000_0000));
      send_item(make_item(KIND_RESPONSE, 8'd1, 8'hAA, 32'h5555_5555, 64'd5));
      send_item(make_item(KIND_RESPONSE, 8'd254, 8'd0, 32'd0, 64'd0));
      send_item(make_item(KIND_REQUEST, 8'd128, 8'd0, 32'd2, 64'd6));
      send_item(make_item(KIND_RESPONSE, 8'd128, 8'd0, 32'd0, 64'd0));

      // Random part; the tail runs without idling on either side
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
         send_item(random_item());
      end
      req_valid <= 1'b0;

      // let the monitor count the last transfer before waiting for the queue to drain
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d inbound requests and %0d outbound responses, directed then random,",
               n_requests, n_responses);
      $display("with idle bursts on both channels and a final stretch at full rate.");
      if (failures == 0 && pending == 0) begin
         $display("client_session_sequence_checker_tb: PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", failures, pending);
         $display("client_session_sequence_checker_tb: FAIL");
      end
      $finish;
   end

endmodule
